// File: src/sh4_pkg.sv
// Shared constants, fixed-point helpers and types for the degree-4 spherical harmonics core.
// Depends on nothing; imported by spherical_harmonics_to_l4_core.
package sh4_pkg;

    localparam int QW = 36;
    typedef logic signed [QW-1:0] q_t;

    localparam q_t ONE_Q30   = 36'sd1073741824;
    localparam q_t SIN_FLOOR = 36'sd10737;

    localparam q_t K00 = 36'sd302896976;
    localparam q_t K10 = 36'sd524632952;
    localparam q_t K11 = 36'sd370971518;
    localparam q_t K20 = 36'sd338649115;
    localparam q_t K21 = 36'sd829517532;
    localparam q_t K22 = 36'sd414758766;
    localparam q_t K30 = 36'sd400695036;
    localparam q_t K31 = 36'sd347012080;
    localparam q_t K32 = 36'sd1097348550;
    localparam q_t K33 = 36'sd447990669;
    localparam q_t K40 = 36'sd113586366;
    localparam q_t K41 = 36'sd507973672;
    localparam q_t K42 = 36'sd359191628;
    localparam q_t K43 = 36'sd1343972008;
    localparam q_t K44 = 36'sd475165860;

    localparam logic [2:0] DEG_MAX = 3'd4;
    localparam logic signed [3:0] ORD_MAX = 4'sd4;

    // Q30 product, round to nearest with ties away from zero
    function automatic q_t qmul(input q_t a, input q_t b);
        logic [QW-1:0]   ma;
        logic [QW-1:0]   mb;
        logic [2*QW-1:0] p;
        logic [QW-1:0]   r;
        ma = a[QW-1] ? QW'(-a) : QW'(a);
        mb = b[QW-1] ? QW'(-b) : QW'(b);
        p  = ma * mb;
        r  = QW'((p + 72'd536870912) >> 30);
        return (a[QW-1] ^ b[QW-1]) ? -q_t'(r) : q_t'(r);
    endfunction

    // Q30 to Q18 with rounding and saturation
    function automatic logic [19:0] to_q18(input q_t v);
        logic [QW-1:0] mg;
        logic [QW-1:0] m;
        mg = v[QW-1] ? QW'(-v) : QW'(v);
        m  = (mg + 36'd2048) >> 12;
        if (v[QW-1])
        begin
            if (m > 36'd524288)
            begin
                m = 36'd524288;
            end
            return 20'(-m);
        end
        if (m > 36'd524287)
        begin
            m = 36'd524287;
        end
        return 20'(m);
    endfunction

    // slot of Y_l,|m| in the coefficient bank
    function automatic logic [3:0] bank_slot(input logic [2:0] l, input logic [2:0] k);
        logic [3:0] base;
        case (l)
            3'd0:    base = 4'd0;
            3'd1:    base = 4'd1;
            3'd2:    base = 4'd3;
            3'd3:    base = 4'd6;
            default: base = 4'd10;
        endcase
        return base + {1'b0, k};
    endfunction

endpackage

// File: src/spherical_harmonics_to_l4_core.sv
// Degree 0..4 complex spherical harmonics core: sqrt unit, divider, product pipeline, emitter.
// Depends on sh4_pkg for constants, rounding helpers and the Q30 product.
//
// The core takes a signed 24-bit (x, y, z) vector and emits the 25 complex harmonics Y_lm of
// its direction, l from 0 to 4 and m from -l to +l, each as a signed Q18 real and imaginary
// part, rounded and saturated; tlast marks Y_4,4. A zero vector reads as the +z direction, and
// a direction within about 1e-5 of the z axis gets phi = 0. Inside, a two-lane bit-serial
// square root forms |r| and |r_xy|, a four-lane restoring divider forms cos/sin of theta
// and phi, a four-stage product pipeline builds the coefficient bank, and an emitter sends
// one harmonic per cycle through two registered stages. Each unit holds its own vector, so a
// new vector transfers while earlier ones are still in flight: the square root unit sets the
// sustained rate. Back-pressure on the output stalls the emitter and then the stages behind
// it without losing or repeating anything.
module spherical_harmonics_to_l4_core
    import sh4_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // x_coord[23:0], y_coord[47:24], z_coord[71:48]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // degree[2:0], order[6:3], real_part[26:7],
                                        // imag_part[46:27], zero fill [47]
    output logic        m_axis_tlast
);

    typedef struct packed {
        logic [63:0] rad_r;
        logic [63:0] rad_h;
        logic [33:0] rem_r;
        logic [33:0] rem_h;
        logic [31:0] root_r;
        logic [31:0] root_h;
        logic [5:0]  cnt;
        logic        xn;
        logic        yn;
        logic        zn;
        logic [23:0] ax;
        logic [23:0] ay;
        logic [23:0] az;
        logic        zero;
    } sq_t;

    typedef struct packed {
        logic [3:0][32:0] rem;
        logic [3:0][30:0] sh;
        logic [3:0][30:0] q;
        logic [31:0]      den_r;
        logic [31:0]      den_h;
        logic [4:0]       cnt;
        logic             xn;
        logic             yn;
        logic             zn;
        logic             zero;
    } dv_t;

    typedef struct packed {
        q_t ct; q_t st; q_t cp; q_t sp;
        q_t cc; q_t ss; q_t scp; q_t ct2; q_t st2; q_t sc;
    } p1_t;

    typedef struct packed {
        q_t ct; q_t cp; q_t sp; q_t ct2; q_t st3; q_t st4; q_t ct4; q_t pc2; q_t ps2;
        q_t t30; q_t t31; q_t t32; q_t t41; q_t t42;
        q_t s10; q_t s11; q_t s20; q_t s21; q_t s22;
    } p2_t;

    typedef struct packed {
        q_t pc2; q_t ps2; q_t pc3; q_t ps3; q_t pc4; q_t ps4; q_t cp; q_t sp;
        q_t s10; q_t s11; q_t s20; q_t s21; q_t s22;
        q_t s30; q_t s31; q_t s32; q_t s33;
        q_t s40; q_t s41; q_t s42; q_t t43; q_t s44;
    } p3_t;

    typedef struct packed {
        q_t [14:0] s;
        q_t [4:0]  pc;
        q_t [4:0]  ps;
    } bank_t;

    typedef struct packed {
        q_t                re;
        q_t                im;
        logic [2:0]        deg;
        logic signed [3:0] ord;
        logic              neg_re;
        logic              neg_im;
        logic              last;
    } e1_t;

    function automatic logic [65:0] sqrt_step(input logic [33:0] rem, input logic [31:0] root,
                                              input logic [1:0] two);
        logic [35:0] r2;
        logic [35:0] trial;
        r2    = {rem, two};
        trial = {2'b00, root, 2'b01};
        if (r2 >= trial)
        begin
            return {34'(r2 - trial), root[30:0], 1'b1};
        end
        return {r2[33:0], root[30:0], 1'b0};
    endfunction

    function automatic logic [63:0] div_step(input logic [32:0] rem, input logic [30:0] q,
                                             input logic nb, input logic [31:0] den);
        logic [33:0] r2;
        r2 = {rem, nb};
        if (r2 >= {2'b00, den})
        begin
            return {33'(r2 - {2'b00, den}), q[29:0], 1'b1};
        end
        return {r2[32:0], q[29:0], 1'b0};
    endfunction

    function automatic q_t clampq(input logic [30:0] q);
        return (q > 31'd1073741824) ? ONE_Q30 : q_t'(q);
    endfunction

    // control registers
    logic sq_v_reg, sq_v_next;
    logic dv_v_reg, dv_v_next;
    logic p1_v_reg, p1_v_next;
    logic p2_v_reg, p2_v_next;
    logic p3_v_reg, p3_v_next;
    logic p4_v_reg, p4_v_next;
    logic e1_v_reg, e1_v_next;
    logic out_v_reg, out_v_next;
    logic [2:0]        deg_reg, deg_next;
    logic signed [3:0] ord_reg, ord_next;

    // payload registers
    sq_t   sq_reg, sq_next;
    dv_t   dv_reg, dv_next;
    p1_t   p1_reg, p1_next;
    p2_t   p2_reg, p2_next;
    p3_t   p3_reg, p3_next;
    bank_t p4_reg, p4_next;
    e1_t   e1_reg, e1_next;
    logic [47:0] out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;

    logic accept, sq_fin, dv_fin;
    logic dv_load, p1_load, p2_load, p3_load, p4_load, e1_load, e2_load;
    logic issue, seq_last;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign sq_fin   = sq_v_reg && (sq_reg.cnt == 6'd32);
    assign dv_fin   = dv_v_reg && (dv_reg.cnt == 5'd31);
    assign seq_last = (deg_reg == DEG_MAX) && (ord_reg == ORD_MAX);

    // elastic chain: a stage loads when empty or when its content moves on
    assign e2_load = !out_v_reg || m_axis_tready;
    assign e1_load = !e1_v_reg || e2_load;
    assign issue   = p4_v_reg && e1_load;
    assign p4_load = !p4_v_reg || (issue && seq_last);
    assign p3_load = !p3_v_reg || p4_load;
    assign p2_load = !p2_v_reg || p3_load;
    assign p1_load = !p1_v_reg || p2_load;
    assign dv_load = !dv_v_reg || (dv_fin && p1_load);

    assign s_axis_tready = !sq_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        sq_v_next  = sq_v_reg;
        dv_v_next  = dv_load ? sq_fin : dv_v_reg;
        p1_v_next  = p1_load ? dv_fin : p1_v_reg;
        p2_v_next  = p2_load ? p1_v_reg : p2_v_reg;
        p3_v_next  = p3_load ? p2_v_reg : p3_v_reg;
        p4_v_next  = p4_load ? p3_v_reg : p4_v_reg;
        e1_v_next  = e1_load ? p4_v_reg : e1_v_reg;
        out_v_next = e2_load ? e1_v_reg : out_v_reg;
        if (accept)
        begin
            sq_v_next = 1'b1;
        end
        else if (sq_fin && dv_load)
        begin
            sq_v_next = 1'b0;
        end
        deg_next = deg_reg;
        ord_next = ord_reg;
        if (issue)
        begin
            if (seq_last)
            begin
                deg_next = 3'd0;
                ord_next = 4'sd0;
            end
            else if (ord_reg == $signed({1'b0, deg_reg}))
            begin
                deg_next = deg_reg + 3'd1;
                ord_next = -$signed({1'b0, deg_reg + 3'd1});
            end
            else
            begin
                ord_next = ord_reg + 4'sd1;
            end
        end
    end

    // square root unit: load on transfer, then two radicand bits per cycle
    logic signed [23:0] xs, ys, zs;
    logic [23:0] ax_in, ay_in, az_in;
    logic [47:0] hsq_in, tsq_in;
    logic [65:0] st_r, st_h;

    assign xs     = s_axis_tdata[23:0];
    assign ys     = s_axis_tdata[47:24];
    assign zs     = s_axis_tdata[71:48];
    assign ax_in  = xs[23] ? 24'(-xs) : 24'(xs);
    assign ay_in  = ys[23] ? 24'(-ys) : 24'(ys);
    assign az_in  = zs[23] ? 24'(-zs) : 24'(zs);
    assign hsq_in = 48'(ax_in) * 48'(ax_in) + 48'(ay_in) * 48'(ay_in);
    assign tsq_in = hsq_in + 48'(az_in) * 48'(az_in);
    assign st_r   = sqrt_step(sq_reg.rem_r, sq_reg.root_r, sq_reg.rad_r[63:62]);
    assign st_h   = sqrt_step(sq_reg.rem_h, sq_reg.root_h, sq_reg.rad_h[63:62]);

    always_comb
    begin
        sq_next = sq_reg;
        if (accept)
        begin
            sq_next.rad_r  = {tsq_in, 16'd0};
            sq_next.rad_h  = {hsq_in, 16'd0};
            sq_next.rem_r  = '0;
            sq_next.rem_h  = '0;
            sq_next.root_r = '0;
            sq_next.root_h = '0;
            sq_next.cnt    = '0;
            sq_next.xn     = xs[23];
            sq_next.yn     = ys[23];
            sq_next.zn     = zs[23];
            sq_next.ax     = ax_in;
            sq_next.ay     = ay_in;
            sq_next.az     = az_in;
            sq_next.zero   = (tsq_in == 48'd0);
        end
        else if (sq_v_reg && !sq_fin)
        begin
            {sq_next.rem_r, sq_next.root_r} = st_r;
            {sq_next.rem_h, sq_next.root_h} = st_h;
            sq_next.rad_r = {sq_reg.rad_r[61:0], 2'b00};
            sq_next.rad_h = {sq_reg.rad_h[61:0], 2'b00};
            sq_next.cnt   = sq_reg.cnt + 6'd1;
        end
    end

    // divider: lanes cos theta, sin theta, cos phi, sin phi; one quotient bit per cycle
    always_comb
    begin
        dv_next = dv_reg;
        if (dv_load && sq_fin)
        begin
            dv_next.den_r  = sq_reg.root_r;
            dv_next.den_h  = sq_reg.root_h;
            dv_next.rem[0] = {2'b00, sq_reg.az, 7'd0};
            dv_next.sh[0]  = '0;
            dv_next.rem[1] = {2'b00, sq_reg.root_h[31:1]};
            dv_next.sh[1]  = {sq_reg.root_h[0], 30'd0};
            dv_next.rem[2] = {2'b00, sq_reg.ax, 7'd0};
            dv_next.sh[2]  = '0;
            dv_next.rem[3] = {2'b00, sq_reg.ay, 7'd0};
            dv_next.sh[3]  = '0;
            dv_next.q      = '0;
            dv_next.cnt    = '0;
            dv_next.xn     = sq_reg.xn;
            dv_next.yn     = sq_reg.yn;
            dv_next.zn     = sq_reg.zn;
            dv_next.zero   = sq_reg.zero;
        end
        else if (dv_v_reg && !dv_fin)
        begin
            for (int i = 0; i < 4; i++)
            begin
                {dv_next.rem[i], dv_next.q[i]} = div_step(dv_reg.rem[i], dv_reg.q[i],
                    dv_reg.sh[i][30], (i < 2) ? dv_reg.den_r : dv_reg.den_h);
                dv_next.sh[i] = {dv_reg.sh[i][29:0], 1'b0};
            end
            dv_next.cnt = dv_reg.cnt + 5'd1;
        end
    end

    // angle terms with the zero-vector and near-axis cases
    q_t ct_v, st_v, cp_v, sp_v, ctm, cpm, spm;
    logic phi_ok;

    always_comb
    begin
        ctm    = clampq(dv_reg.q[0]);
        cpm    = clampq(dv_reg.q[2]);
        spm    = clampq(dv_reg.q[3]);
        st_v   = dv_reg.zero ? '0 : clampq(dv_reg.q[1]);
        ct_v   = dv_reg.zero ? ONE_Q30 : (dv_reg.zn ? -ctm : ctm);
        phi_ok = !dv_reg.zero && (st_v > SIN_FLOOR) && (dv_reg.den_h != 32'd0);
        cp_v   = phi_ok ? (dv_reg.xn ? -cpm : cpm) : ONE_Q30;
        sp_v   = phi_ok ? (dv_reg.yn ? -spm : spm) : '0;
    end

    // product stage 1: squares and cross terms
    always_comb
    begin
        p1_next.ct  = ct_v;
        p1_next.st  = st_v;
        p1_next.cp  = cp_v;
        p1_next.sp  = sp_v;
        p1_next.cc  = qmul(cp_v, cp_v);
        p1_next.ss  = qmul(sp_v, sp_v);
        p1_next.scp = qmul(sp_v, cp_v);
        p1_next.ct2 = qmul(ct_v, ct_v);
        p1_next.st2 = qmul(st_v, st_v);
        p1_next.sc  = qmul(st_v, ct_v);
    end

    // product stage 2: double angle, powers, Legendre factors, low-degree terms
    q_t a20, a30, a31, a41, a42;

    always_comb
    begin
        a20 = 3 * p1_reg.ct2 - ONE_Q30;
        a30 = 5 * p1_reg.ct2 - 3 * ONE_Q30;
        a31 = 5 * p1_reg.ct2 - ONE_Q30;
        a41 = 7 * p1_reg.ct2 - 3 * ONE_Q30;
        a42 = 7 * p1_reg.ct2 - ONE_Q30;
        p2_next.ct  = p1_reg.ct;
        p2_next.cp  = p1_reg.cp;
        p2_next.sp  = p1_reg.sp;
        p2_next.ct2 = p1_reg.ct2;
        p2_next.pc2 = p1_reg.cc - p1_reg.ss;
        p2_next.ps2 = p1_reg.scp + p1_reg.scp;
        p2_next.ct4 = qmul(p1_reg.ct2, p1_reg.ct2);
        p2_next.st3 = qmul(p1_reg.st2, p1_reg.st);
        p2_next.st4 = qmul(p1_reg.st2, p1_reg.st2);
        p2_next.t30 = qmul(a30, p1_reg.ct);
        p2_next.t31 = qmul(a31, p1_reg.st);
        p2_next.t32 = qmul(p1_reg.st2, p1_reg.ct);
        p2_next.t41 = qmul(a41, p1_reg.sc);
        p2_next.t42 = qmul(a42, p1_reg.st2);
        p2_next.s10 = qmul(K10, p1_reg.ct);
        p2_next.s11 = qmul(K11, p1_reg.st);
        p2_next.s20 = qmul(K20, a20);
        p2_next.s21 = qmul(K21, p1_reg.sc);
        p2_next.s22 = qmul(K22, p1_reg.st2);
    end

    // product stage 3: triple and quadruple angle, degree 3 and 4 terms
    logic signed [39:0] a40w;

    always_comb
    begin
        a40w = 40'(p2_reg.ct4) * 40'sd35 - 40'(p2_reg.ct2) * 40'sd30 + 40'(ONE_Q30) * 40'sd3;
        p3_next.pc2 = p2_reg.pc2;
        p3_next.ps2 = p2_reg.ps2;
        p3_next.cp  = p2_reg.cp;
        p3_next.sp  = p2_reg.sp;
        p3_next.pc3 = qmul(p2_reg.pc2, p2_reg.cp) - qmul(p2_reg.ps2, p2_reg.sp);
        p3_next.ps3 = qmul(p2_reg.ps2, p2_reg.cp) + qmul(p2_reg.pc2, p2_reg.sp);
        p3_next.pc4 = qmul(p2_reg.pc2, p2_reg.pc2) - qmul(p2_reg.ps2, p2_reg.ps2);
        p3_next.ps4 = 2 * qmul(p2_reg.ps2, p2_reg.pc2);
        p3_next.s10 = p2_reg.s10;
        p3_next.s11 = p2_reg.s11;
        p3_next.s20 = p2_reg.s20;
        p3_next.s21 = p2_reg.s21;
        p3_next.s22 = p2_reg.s22;
        p3_next.s30 = qmul(K30, p2_reg.t30);
        p3_next.s31 = qmul(K31, p2_reg.t31);
        p3_next.s32 = qmul(K32, p2_reg.t32);
        p3_next.s33 = qmul(K33, p2_reg.st3);
        p3_next.s40 = qmul(K40, q_t'(a40w));
        p3_next.s41 = qmul(K41, p2_reg.t41);
        p3_next.s42 = qmul(K42, p2_reg.t42);
        p3_next.t43 = qmul(p2_reg.st3, p2_reg.ct);
        p3_next.s44 = qmul(K44, p2_reg.st4);
    end

    // stage 4: coefficient bank, held until the last harmonic of the vector issues
    always_comb
    begin
        p4_next.s[0]   = K00;
        p4_next.s[1]   = p3_reg.s10;
        p4_next.s[2]   = p3_reg.s11;
        p4_next.s[3]   = p3_reg.s20;
        p4_next.s[4]   = p3_reg.s21;
        p4_next.s[5]   = p3_reg.s22;
        p4_next.s[6]   = p3_reg.s30;
        p4_next.s[7]   = p3_reg.s31;
        p4_next.s[8]   = p3_reg.s32;
        p4_next.s[9]   = p3_reg.s33;
        p4_next.s[10]  = p3_reg.s40;
        p4_next.s[11]  = p3_reg.s41;
        p4_next.s[12]  = p3_reg.s42;
        p4_next.s[13]  = qmul(K43, p3_reg.t43);
        p4_next.s[14]  = p3_reg.s44;
        p4_next.pc[0]  = ONE_Q30;
        p4_next.ps[0]  = '0;
        p4_next.pc[1]  = p3_reg.cp;
        p4_next.ps[1]  = p3_reg.sp;
        p4_next.pc[2]  = p3_reg.pc2;
        p4_next.ps[2]  = p3_reg.ps2;
        p4_next.pc[3]  = p3_reg.pc3;
        p4_next.ps[3]  = p3_reg.ps3;
        p4_next.pc[4]  = p3_reg.pc4;
        p4_next.ps[4]  = p3_reg.ps4;
    end

    // emitter stage 1: pick the bank entry and apply the phase factor
    logic [2:0] kk;
    q_t         s_sel;

    always_comb
    begin
        kk    = ord_reg[3] ? 3'(-ord_reg) : 3'(ord_reg);
        s_sel = p4_reg.s[bank_slot(deg_reg, kk)];
        e1_next.re     = qmul(s_sel, p4_reg.pc[kk]);
        e1_next.im     = qmul(s_sel, p4_reg.ps[kk]);
        e1_next.deg    = deg_reg;
        e1_next.ord    = ord_reg;
        e1_next.neg_re = (ord_reg > 4'sd0) && kk[0];
        e1_next.neg_im = ord_reg[3] || ((ord_reg > 4'sd0) && kk[0]);
        e1_next.last   = seq_last;
    end

    // emitter stage 2: sign, round to Q18, saturate into the output register
    always_comb
    begin
        out_data_next = {1'b0,
                         to_q18(e1_reg.neg_im ? -e1_reg.im : e1_reg.im),
                         to_q18(e1_reg.neg_re ? -e1_reg.re : e1_reg.re),
                         e1_reg.ord, e1_reg.deg};
        out_last_next = e1_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg  <= 1'b0;
            dv_v_reg  <= 1'b0;
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            p4_v_reg  <= 1'b0;
            e1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            deg_reg   <= 3'd0;
            ord_reg   <= 4'sd0;
        end
        else
        begin
            sq_v_reg  <= sq_v_next;
            dv_v_reg  <= dv_v_next;
            p1_v_reg  <= p1_v_next;
            p2_v_reg  <= p2_v_next;
            p3_v_reg  <= p3_v_next;
            p4_v_reg  <= p4_v_next;
            e1_v_reg  <= e1_v_next;
            out_v_reg <= out_v_next;
            deg_reg   <= deg_next;
            ord_reg   <= ord_next;
        end
    end

    // payload: hold unless the stage loads
    always_ff @(posedge clk)
    begin
        sq_reg <= sq_next;
        dv_reg <= dv_next;
        if (p1_load)
        begin
            p1_reg <= p1_next;
        end
        if (p2_load)
        begin
            p2_reg <= p2_next;
        end
        if (p3_load)
        begin
            p3_reg <= p3_next;
        end
        if (p4_load)
        begin
            p4_reg <= p4_next;
        end
        if (e1_load)
        begin
            e1_reg <= e1_next;
        end
        if (e2_load)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    a_last_tag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[2:0] == DEG_MAX
                                          && $signed(m_axis_tdata[6:3]) == ORD_MAX)
        else $error("tlast on a harmonic other than Y_4,4");

    a_seq_rest: assert property (@(posedge clk) disable iff (!rst_n)
        !p4_v_reg |-> deg_reg == 3'd0 && ord_reg == 4'sd0)
        else $error("emitter left mid-vector with an empty bank");

    a_sqrt_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        sq_v_reg && !sq_fin |=> sq_v_reg)
        else $error("square root unit released before its last step");

    a_div_hand: assert property (@(posedge clk) disable iff (!rst_n)
        dv_v_reg && !dv_fin |=> dv_v_reg && $stable(dv_reg.den_r))
        else $error("divider lost its vector mid-division");

endmodule

// File: tb/sh4_checker.sv
`timescale 1ns / 100ps
// Checker for the degree-4 spherical harmonics core: watches both streams, predicts the
// 25 harmonics of each accepted vector and compares every output transfer field by field.
module sh4_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [2:0]        degree;
        logic signed [3:0] order;
        logic [19:0]       re;
        logic [19:0]       im;
        logic              last;
    } harmonic_t;

    localparam longint UNIT = 64'sd1 << 30;
    localparam longint SIN_MIN = 10737;

    harmonic_t harmonics_due[$];

    function automatic longint unsigned mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // Q30 product with rounding half away from zero
    function automatic longint fxmul(input longint a, input longint b);
        longint unsigned p;
        p = (mag(a) * mag(b) + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned root(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
            begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned ratio(input longint unsigned n, input longint unsigned d);
        longint unsigned q;
        q = d != 0 ? n / d : 0;
        return q > UNIT ? UNIT : q;
    endfunction

    function automatic logic [19:0] round_q18(input longint v);
        longint unsigned m;
        m = (mag(v) + 2048) >> 12;
        if (v < 0)
        begin
            if (m > 524288) m = 524288;
            return 20'(-m);
        end
        if (m > 524287) m = 524287;
        return 20'(m);
    endfunction

    // predict all 25 harmonics of one direction vector
    task automatic predict_harmonics(input logic [71:0] vec);
        longint xs, ys, zs, ct, st, cp, sp, ct2, ct4, st2, st3, st4, sc, re, im;
        longint unsigned ax, ay, az, hsq, tsq, rq, hq, q;
        longint pc[5];
        longint ps[5];
        longint amp[5][5];
        harmonic_t h;
        int k;
        xs = longint'($signed(vec[23:0]));
        ys = longint'($signed(vec[47:24]));
        zs = longint'($signed(vec[71:48]));
        ax = mag(xs); ay = mag(ys); az = mag(zs);
        hsq = ax * ax + ay * ay;
        tsq = hsq + az * az;
        ct = UNIT; st = 0; cp = UNIT; sp = 0;
        if (tsq != 0)
        begin
            rq = root(tsq << 16);
            hq = root(hsq << 16);
            q = ratio(az << 38, rq);
            ct = zs < 0 ? -longint'(q) : longint'(q);
            st = longint'(ratio(hq << 30, rq));
            // near the z axis the azimuth is forced to zero
            if (st > SIN_MIN && hq != 0)
            begin
                q = ratio(ax << 38, hq);
                cp = xs < 0 ? -longint'(q) : longint'(q);
                q = ratio(ay << 38, hq);
                sp = ys < 0 ? -longint'(q) : longint'(q);
            end
        end
        pc[0] = UNIT; ps[0] = 0;
        pc[1] = cp;   ps[1] = sp;
        pc[2] = fxmul(cp, cp) - fxmul(sp, sp);
        ps[2] = 2 * fxmul(sp, cp);
        pc[3] = fxmul(pc[2], cp) - fxmul(ps[2], sp);
        ps[3] = fxmul(ps[2], cp) + fxmul(pc[2], sp);
        pc[4] = fxmul(pc[2], pc[2]) - fxmul(ps[2], ps[2]);
        ps[4] = 2 * fxmul(ps[2], pc[2]);
        ct2 = fxmul(ct, ct); ct4 = fxmul(ct2, ct2);
        st2 = fxmul(st, st); st3 = fxmul(st2, st); st4 = fxmul(st2, st2);
        sc = fxmul(st, ct);
        amp[0][0] = 302896976;
        amp[1][0] = fxmul(524632952, ct);
        amp[1][1] = fxmul(370971518, st);
        amp[2][0] = fxmul(338649115, 3 * ct2 - UNIT);
        amp[2][1] = fxmul(829517532, sc);
        amp[2][2] = fxmul(414758766, st2);
        amp[3][0] = fxmul(400695036, fxmul(5 * ct2 - 3 * UNIT, ct));
        amp[3][1] = fxmul(347012080, fxmul(5 * ct2 - UNIT, st));
        amp[3][2] = fxmul(1097348550, fxmul(st2, ct));
        amp[3][3] = fxmul(447990669, st3);
        amp[4][0] = fxmul(113586366, 35 * ct4 - 30 * ct2 + 3 * UNIT);
        amp[4][1] = fxmul(507973672, fxmul(7 * ct2 - 3 * UNIT, sc));
        amp[4][2] = fxmul(359191628, fxmul(7 * ct2 - UNIT, st2));
        amp[4][3] = fxmul(1343972008, fxmul(st3, ct));
        amp[4][4] = fxmul(475165860, st4);
        for (int l = 0; l <= 4; l++)
        begin
            for (int m = -l; m <= l; m++)
            begin
                k = m < 0 ? -m : m;
                re = fxmul(amp[l][k], pc[k]);
                im = fxmul(amp[l][k], ps[k]);
                if (m < 0) im = -im;
                if (m > 0 && k % 2 == 1)
                begin
                    re = -re;
                    im = -im;
                end
                h.degree = 3'(l);
                h.order = 4'(m);
                h.re = round_q18(re);
                h.im = round_q18(im);
                h.last = (l == 4 && m == 4);
                harmonics_due.push_back(h);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    assign pending = harmonics_due.size();

    always @(posedge clk)
    begin
        harmonic_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_harmonics(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (harmonics_due.size() == 0)
                begin
                    report_mismatch("unexpected transfer", 1, 0);
                end
                else
                begin
                    want = harmonics_due.pop_front();
                    if (m_axis_tdata[2:0] !== want.degree)
                        report_mismatch("degree", m_axis_tdata[2:0], want.degree);
                    if (m_axis_tdata[6:3] !== want.order)
                        report_mismatch("order", $signed(m_axis_tdata[6:3]), want.order);
                    if (m_axis_tdata[26:7] !== want.re)
                        report_mismatch("real_part", $signed(m_axis_tdata[26:7]),
                                        $signed(want.re));
                    if (m_axis_tdata[46:27] !== want.im)
                        report_mismatch("imag_part", $signed(m_axis_tdata[46:27]),
                                        $signed(want.im));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("tlast", m_axis_tlast, want.last);
                end
            end
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Testbench top for spherical_harmonics_to_l4_core: drives vectors and output back-pressure.
// Depends on the core and sh4_checker, which predicts and compares every harmonic.
module tb;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          fail_count;
    int          pending;

    // idle chances in percent, changed by phase
    int send_idle_pct;
    int recv_idle_pct;

    spherical_harmonics_to_l4_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    sh4_checker chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: redraw tready at every falling edge.
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Pick a component: extremes, small values, near-zero and full random.
    function automatic logic [23:0] pick_coord();
        case ($urandom_range(7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(6)) - 3);
            3: return 24'($signed($urandom_range(2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    // Hand one vector to the core; hold tvalid until it transfers, drop it only when idling.
    task automatic send_vector(input logic [23:0] x, input logic [23:0] y, input logic [23:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 72'(0);
            @(negedge clk);
        end
        s_axis_tdata  <= {z, y, x};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 72'(0);
        m_axis_tready = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 6;
        recv_idle_pct = 56;
        // Directed: zero vector, axes both ways, near-axis, extremes, all-ones bits.
        send_vector(24'd0, 24'd0, 24'd0);
        send_vector(24'd0, 24'd0, 24'd1);
        send_vector(24'd0, 24'd0, 24'hFFFFFF);
        send_vector(24'd0, 24'd0, 24'h7FFFFF);
        send_vector(24'd0, 24'd0, 24'h800000);
        send_vector(24'd1, 24'd0, 24'd0);
        send_vector(24'hFFFFFF, 24'd0, 24'd0);
        send_vector(24'd0, 24'd1, 24'd0);
        send_vector(24'd0, 24'hFFFFFF, 24'd0);
        send_vector(24'd1, 24'd0, 24'h7FFFFF);
        send_vector(24'd50, 24'd50, 24'h7FFFFF);
        send_vector(24'd200, 24'hFFFF38, 24'h800000);
        send_vector(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_vector(24'h800000, 24'h800000, 24'h800000);
        send_vector(24'h800000, 24'h7FFFFF, 24'd0);
        send_vector(24'hAAAAAA, 24'h555555, 24'hAAAAAA);
        send_vector(24'h555555, 24'hAAAAAA, 24'h555555);
        send_vector(24'd1, 24'd1, 24'd1);
        send_vector(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);

        for (int i = 0; i < 200; i++)
        begin
            // advance idling phase by thirds
            if (i == 67)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 6;
            end
            else if (i == 134)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_vector(pick_coord(), pick_coord(), pick_coord());
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 72'(0);

        while (pending != 0)
        begin
            @(posedge clk);
        end
        // let any stray transfer show up
        repeat (200) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
src/sh4_pkg.sv
src/spherical_harmonics_to_l4_core.sv
tb/sh4_checker.sv
tb/tb.sv
